FILE: src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and codes shared by the priority task dispatcher modules.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // action codes
  localparam logic [1:0] ACT_SUBMIT   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_REPORT   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_BAD_REQ = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         task_id;
    logic signed [15:0] task_priority;
    logic [15:0]        invocation_count;
    logic signed [15:0] required_priority;
    logic               failed;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_task;
    logic [15:0] invocation_index;
    logic        task_done;
  } result_t;

  // one slot of the task table
  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        total;
    logic [15:0]        issued;
    logic [15:0]        finished;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUBMIT,
    S_BAD,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_RD,
    S_REPORT
  } state_t;

endpackage

FILE: src/ptd_mem.sv
// ----------------------------------------------------------------------------
// ptd_mem
// Task table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptd_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ptd_pkg::entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ptd_pkg::entry_t          rdata
);

  ptd_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ptd_scan.sv
// ----------------------------------------------------------------------------
// ptd_scan
// Priority compare unit. Takes one table entry a cycle and keeps the
// best eligible one seen since the last clear.
// ----------------------------------------------------------------------------
module ptd_scan #(
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               vld,
  input  logic [IDX_W-1:0]   idx,
  input  ptd_pkg::entry_t    entry,
  input  logic               queued,
  input  logic signed [15:0] req_prio,
  output logic               found,
  output logic [IDX_W-1:0]   best_idx,
  output ptd_pkg::entry_t    best_entry
);

  logic take;

  // strict greater-than keeps the lowest id on a priority tie
  assign take = vld && queued && (entry.prio >= req_prio) &&
                (!found || (entry.prio > best_entry.prio));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= idx;
      best_entry <= entry;
    end
  end

endmodule

FILE: src/priority_task_dispatcher_top.sv
// ----------------------------------------------------------------------------
// priority_task_dispatcher_top
// Task table with submit, priority dispatch and completion reporting.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on a clock edge with start high and busy low. The
//   command struct carries action, task id, priority, invocation count,
//   minimum priority and the failure flag. Every command gives exactly one
//   result, shown for one cycle with result_valid high; the receiver always
//   takes it and cannot stall the block.
//   Submit and unused actions: result set in S_SUBMIT or S_BAD, then registered.
//   Report: result set in S_REPORT after S_RD, then registered (one table read).
//   Dispatch: the compare unit walks all NUM_TASKS slots, one table read a
//   cycle in S_SCAN, then S_DRAIN and S_PICK, and the result is registered.
//   busy is high from the transfer until the result cycle; a new command may
//   transfer in the cycle the result is shown. A new command is not taken
//   until the current one has given its result.
//   Reset clears queued marks, sets every slot done (free) and leaves the
//   table memory as is; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_task_dispatcher_top #(
  parameter int NUM_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptd_pkg::cmd_t     cmd,
  output logic              result_valid,
  output ptd_pkg::result_t  result
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  ptd_pkg::state_t  state, state_next;
  ptd_pkg::cmd_t    req;
  ptd_pkg::result_t result_next;
  logic             result_valid_next;

  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_vld;

  logic [NUM_TASKS-1:0] queued;
  logic [NUM_TASKS-1:0] done;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  ptd_pkg::entry_t  mem_wdata;
  ptd_pkg::entry_t  mem_rdata;

  logic             q_we, q_val, d_we, d_val;
  logic [IDX_W-1:0] flag_slot;

  logic             found;
  logic [IDX_W-1:0] best_idx;
  ptd_pkg::entry_t  best_entry;

  logic [IDX_W-1:0] slot;
  logic             oob;
  logic [15:0]      cnt_plus;

  assign slot = IDX_W'(req.task_id);
  assign oob  = {5'd0, req.task_id} >= 9'(NUM_TASKS);
  assign busy = (state != ptd_pkg::S_IDLE);

  ptd_mem #(
    .DEPTH (NUM_TASKS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptd_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (state == ptd_pkg::S_IDLE),
    .vld        (scan_vld),
    .idx        (scan_idx),
    .entry      (mem_rdata),
    .queued     (queued[scan_idx]),
    .req_prio   (req.required_priority),
    .found      (found),
    .best_idx   (best_idx),
    .best_entry (best_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptd_pkg::S_IDLE;
      result_valid <= 1'b0;
      scan_vld     <= 1'b0;
      queued       <= '0;
      done         <= '1;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      scan_vld     <= (state == ptd_pkg::S_SCAN);
      if (q_we) begin
        queued[flag_slot] <= q_val;
      end
      if (d_we) begin
        done[flag_slot] <= d_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= cmd;
    end
    cnt      <= cnt_next;
    scan_idx <= cnt;
    result   <= result_next;
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    result_valid_next = 1'b0;
    result_next       = '0;
    mem_we            = 1'b0;
    mem_waddr         = slot;
    mem_wdata         = mem_rdata;
    mem_raddr         = slot;
    q_we              = 1'b0;
    q_val             = 1'b0;
    d_we              = 1'b0;
    d_val             = 1'b0;
    flag_slot         = slot;
    cnt_plus          = mem_rdata.finished + 16'd1;

    unique case (state)
      ptd_pkg::S_IDLE: begin
        cnt_next = '0;
        if (start) begin
          unique case (cmd.action)
            ptd_pkg::ACT_SUBMIT:   state_next = ptd_pkg::S_SUBMIT;
            ptd_pkg::ACT_DISPATCH: state_next = ptd_pkg::S_SCAN;
            ptd_pkg::ACT_REPORT:   state_next = ptd_pkg::S_RD;
            default:               state_next = ptd_pkg::S_BAD;
          endcase
        end
      end

      ptd_pkg::S_SUBMIT: begin
        result_valid_next       = 1'b1;
        result_next.chosen_task = req.task_id;
        state_next              = ptd_pkg::S_IDLE;
        if (oob) begin
          result_next.status = ptd_pkg::ST_BAD_REQ;
        end else if (!done[slot]) begin
          result_next.status = ptd_pkg::ST_BUSY;
        end else begin
          mem_we                  = 1'b1;
          mem_wdata.prio          = req.task_priority;
          mem_wdata.total         = req.invocation_count;
          mem_wdata.issued        = '0;
          mem_wdata.finished      = '0;
          q_we                    = 1'b1;
          q_val                   = (req.invocation_count != 16'd0);
          d_we                    = 1'b1;
          d_val                   = (req.invocation_count == 16'd0);
          result_next.status      = ptd_pkg::ST_OK;
          result_next.task_done   = (req.invocation_count == 16'd0);
        end
      end

      ptd_pkg::S_BAD: begin
        result_valid_next  = 1'b1;
        result_next.status = ptd_pkg::ST_BAD_REQ;
        state_next         = ptd_pkg::S_IDLE;
      end

      ptd_pkg::S_SCAN: begin
        mem_raddr = cnt;
        cnt_next  = cnt + 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = ptd_pkg::S_DRAIN;
        end
      end

      // last slot's data reaches the compare unit here
      ptd_pkg::S_DRAIN: begin
        state_next = ptd_pkg::S_PICK;
      end

      ptd_pkg::S_PICK: begin
        result_valid_next = 1'b1;
        state_next        = ptd_pkg::S_IDLE;
        if (!found) begin
          result_next.status = ptd_pkg::ST_NONE;
        end else begin
          mem_we                       = 1'b1;
          mem_waddr                    = best_idx;
          mem_wdata                    = best_entry;
          mem_wdata.issued             = best_entry.issued + 16'd1;
          flag_slot                    = best_idx;
          q_we                         = (mem_wdata.issued >= best_entry.total);
          q_val                        = 1'b0;
          result_next.status           = ptd_pkg::ST_OK;
          result_next.chosen_task      = 4'(best_idx);
          result_next.invocation_index = best_entry.issued;
        end
      end

      ptd_pkg::S_RD: begin
        state_next = ptd_pkg::S_REPORT;
      end

      ptd_pkg::S_REPORT: begin
        result_valid_next       = 1'b1;
        result_next.chosen_task = req.task_id;
        state_next              = ptd_pkg::S_IDLE;
        if (oob) begin
          result_next.status = ptd_pkg::ST_BAD_REQ;
        end else if (done[slot] || (mem_rdata.finished >= mem_rdata.issued)) begin
          result_next.status    = ptd_pkg::ST_BAD_REQ;
          result_next.task_done = done[slot];
        end else begin
          mem_we             = 1'b1;
          mem_wdata.finished = cnt_plus;
          result_next.status = ptd_pkg::ST_OK;
          if (req.failed || (cnt_plus >= mem_rdata.total)) begin
            q_we                  = 1'b1;
            q_val                 = 1'b0;
            d_we                  = 1'b1;
            d_val                 = 1'b1;
            result_next.task_done = 1'b1;
          end
        end
      end

      default: begin
        state_next = ptd_pkg::S_IDLE;
      end
    endcase
  end

endmodule
